FILE: design/fkf_pkg.sv
`default_nettype none

package fkf_pkg;

    // Field widths of the stream payloads.
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int KEY_W      = 32;
    localparam int MAC_W      = 48;
    localparam int TYPE_W     = 8;
    localparam int POS_W      = 16;
    localparam int IN_DATA_W  = KEY_W + MAC_W + TYPE_W;
    localparam int OUT_DATA_W = POS_W + KEY_W;

    // Hash bytes: six MAC bytes followed by the type byte.
    localparam int HASH_BYTES = (MAC_W + TYPE_W) / 8;

    // 32-bit FNV-1a constants.
    localparam logic [KEY_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [KEY_W-1:0] FNV_PRIME = 32'd16777619;

    // Command carried on the input sideband.
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_SEED   = 2'd1,
        CMD_DETECT = 2'd2
    } cmd_t;

    // Result status carried on the output sideband.
    typedef enum logic [STATUS_W-1:0] {
        ST_NEW  = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

endpackage

`default_nettype wire

FILE: design/first_seen_key_filter_unit.sv
`default_nettype none

// Deduplicating key filter. Each input beat carries a command: clear empties the key set
// and zeroes the detection position, seed inserts ring_key, and detect hashes the MAC and
// type byte with 32-bit FNV-1a (a zero hash becomes 1) and inserts that key. Every command
// returns exactly one output beat with status new, duplicate or full; a new detection also
// reports its detection position. The set is a linear-probing table of TABLE_SLOTS slots
// held in one single-port-read, single-port-write memory, and it refuses inserts once
// half of the slots are used. The block works on one beat at a time. Each probe of a slot
// is a memory read, then a compare; a detect first runs its seven hash rounds, one multiply
// per cycle on a single multiplier. When TABLE_SLOTS is not a power of two, the home slot
// is found by a reciprocal multiplication and one fold. A full result skips probing. A
// clear sweeps the table one slot per cycle. A result that the sink has not yet taken holds
// the block in its result state. After reset the same sweep runs, and no beat is accepted
// until it completes.
module first_seen_key_filter_unit #(
    parameter int TABLE_SLOTS = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input stream.
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: ring_key[31:0], mac[79:32], device_type[87:80].
    input  wire logic [fkf_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: command[1:0].
    input  wire logic [fkf_pkg::CMD_W-1:0]     s_axis_tuser,
    // Output stream.
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: position[15:0], hashed_key[47:16].
    output logic [fkf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tuser: status[1:0].
    output logic [fkf_pkg::STATUS_W-1:0]       m_axis_tuser
);

    import fkf_pkg::*;

    localparam int IDX_W    = $clog2(TABLE_SLOTS);
    localparam int FULL_AT  = TABLE_SLOTS / 2;
    localparam bit IS_POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam int HB_W     = 8 * HASH_BYTES;
    localparam int ROUND_W  = $clog2(HASH_BYTES);
    localparam int PROD_W   = 2 * KEY_W + 1;
    localparam int RECIP_SH = KEY_W + IDX_W;

    // Reciprocal of the table size, rounded up, so that the high product bits give the
    // exact quotient for every 32-bit key.
    localparam logic [KEY_W:0] RECIP_M = (KEY_W+1)'(((PROD_W'(1) << RECIP_SH)
        + PROD_W'(TABLE_SLOTS) - PROD_W'(1)) / PROD_W'(TABLE_SLOTS));

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_KEY,
        S_MOD,
        S_FOLD,
        S_READ,
        S_CHECK,
        S_RESULT
    } state_t;

    state_t                state_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  report_clear_reg;
    logic [IDX_W-1:0]      entry_cnt_reg;
    logic [POS_W-1:0]      det_pos_reg;
    logic                  is_detect_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [HB_W-1:0]       bytes_reg;
    logic [ROUND_W-1:0]    round_reg;
    logic [KEY_W-1:0]      quot_reg;
    status_t               res_status_reg;
    logic [POS_W-1:0]      res_pos_reg;
    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [POS_W-1:0]      m_pos_reg;
    logic [KEY_W-1:0]      m_key_reg;
    logic [KEY_W:0]        rd_data_reg;

    // Slot memory: bit 32 marks an occupied slot, bits 31:0 hold the key.
    logic [KEY_W:0]        slot_mem [TABLE_SLOTS];

    logic [KEY_W-1:0]      hash_prod;
    logic [PROD_W-1:0]     recip_prod;
    logic [IDX_W-1:0]      fold_lo;
    logic [IDX_W-1:0]      idx_inc;
    logic                  slot_empty;
    logic                  slot_hit;
    logic                  wr_en;
    logic [KEY_W:0]        wr_data;
    cmd_t                  in_cmd;

    assign in_cmd = cmd_t'(s_axis_tuser);

    // One FNV-1a round: fold in the next byte, then multiply by the prime.
    assign hash_prod = (key_reg ^ {{(KEY_W-8){1'b0}}, bytes_reg[HB_W-1 -: 8]}) * FNV_PRIME;

    // Home slot for a table size that is not a power of two: the quotient comes from the
    // high bits of the product with the reciprocal, and the remainder from one fold.
    assign recip_prod = PROD_W'(key_reg) * PROD_W'(RECIP_M);
    assign fold_lo    = quot_reg[IDX_W-1:0] * IDX_W'(TABLE_SLOTS);

    // Next probe slot, wrapping round the table.
    assign idx_inc = (idx_reg == IDX_W'(TABLE_SLOTS - 1)) ? '0 : idx_reg + 1'b1;

    // Compare of the slot read in the previous cycle.
    assign slot_empty = !rd_data_reg[KEY_W];
    assign slot_hit   = rd_data_reg[KEY_W-1:0] == key_reg;

    // Memory write: the sweep clears slots, a probe ending on an empty slot claims it.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = '0;
        if (state_reg == S_CLEAR)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == S_CHECK && slot_empty)
        begin
            wr_en   = 1'b1;
            wr_data = {1'b1, key_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[idx_reg] <= wr_data;
        end
        rd_data_reg <= slot_mem[idx_reg];
    end

    // Sequencer with the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            idx_reg          <= '0;
            report_clear_reg <= 1'b0;
            entry_cnt_reg    <= '0;
            det_pos_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            // The result state keeps the output register valid itself.
            if (m_axis_tready && state_reg != S_RESULT)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    if (idx_reg == IDX_W'(TABLE_SLOTS - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= report_clear_reg ? S_RESULT : S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        case (in_cmd)
                            CMD_CLEAR:
                            begin
                                entry_cnt_reg    <= '0;
                                det_pos_reg      <= '0;
                                key_reg          <= '0;
                                res_status_reg   <= ST_NEW;
                                res_pos_reg      <= '0;
                                report_clear_reg <= 1'b1;
                                idx_reg          <= '0;
                                state_reg        <= S_CLEAR;
                            end
                            CMD_SEED:
                            begin
                                key_reg       <= s_axis_tdata[KEY_W-1:0];
                                is_detect_reg <= 1'b0;
                                state_reg     <= S_KEY;
                            end
                            CMD_DETECT:
                            begin
                                // MAC bytes first, first byte on top, then the type byte.
                                key_reg       <= FNV_BASIS;
                                bytes_reg     <= {s_axis_tdata[KEY_W+MAC_W-1:KEY_W],
                                                  s_axis_tdata[IN_DATA_W-1:KEY_W+MAC_W]};
                                round_reg     <= '0;
                                is_detect_reg <= 1'b1;
                                state_reg     <= S_HASH;
                            end
                            default:
                            begin
                                key_reg        <= '0;
                                res_status_reg <= ST_NEW;
                                res_pos_reg    <= '0;
                                state_reg      <= S_RESULT;
                            end
                        endcase
                    end
                end

                S_HASH:
                begin
                    bytes_reg <= bytes_reg << 8;
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == ROUND_W'(HASH_BYTES - 1))
                    begin
                        key_reg   <= (hash_prod == '0) ? KEY_W'(1) : hash_prod;
                        state_reg <= S_KEY;
                    end
                    else
                    begin
                        key_reg <= hash_prod;
                    end
                end

                S_KEY:
                begin
                    if (entry_cnt_reg >= IDX_W'(FULL_AT))
                    begin
                        res_status_reg <= ST_FULL;
                        res_pos_reg    <= '0;
                        state_reg      <= S_RESULT;
                    end
                    else if (IS_POW2)
                    begin
                        idx_reg   <= key_reg[IDX_W-1:0];
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_MOD;
                    end
                end

                S_MOD:
                begin
                    quot_reg  <= KEY_W'(recip_prod >> RECIP_SH);
                    state_reg <= S_FOLD;
                end

                S_FOLD:
                begin
                    idx_reg   <= key_reg[IDX_W-1:0] - fold_lo;
                    state_reg <= S_READ;
                end

                S_READ:
                begin
                    state_reg <= S_CHECK;
                end

                S_CHECK:
                begin
                    if (slot_empty)
                    begin
                        entry_cnt_reg  <= entry_cnt_reg + 1'b1;
                        res_status_reg <= ST_NEW;
                        res_pos_reg    <= is_detect_reg ? det_pos_reg : '0;
                        if (is_detect_reg)
                        begin
                            det_pos_reg <= det_pos_reg + 1'b1;
                        end
                        state_reg <= S_RESULT;
                    end
                    else if (slot_hit)
                    begin
                        res_status_reg <= ST_DUP;
                        res_pos_reg    <= '0;
                        if (is_detect_reg)
                        begin
                            det_pos_reg <= det_pos_reg + 1'b1;
                        end
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_READ;
                    end
                end

                S_RESULT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg      <= 1'b1;
                        m_status_reg     <= res_status_reg;
                        m_pos_reg        <= res_pos_reg;
                        m_key_reg        <= key_reg;
                        report_clear_reg <= 1'b0;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Stream ports.
    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_key_reg, m_pos_reg};
    assign m_axis_tuser  = m_status_reg;

    // The table never holds more than half of its slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_cnt_reg <= IDX_W'(FULL_AT))
    else $error("entry count passed the half-full limit");

    // A clear beat starts the table sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_CLEAR) |=> state_reg == S_CLEAR)
    else $error("clear beat did not start the sweep");

    // Only a newly added key can carry a nonzero position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_NEW) |-> m_axis_tdata[POS_W-1:0] == '0)
    else $error("position reported on a duplicate or full result");

    // A finished hash never yields the reserved zero key.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_KEY && is_detect_reg) |-> key_reg != '0)
    else $error("detection key is zero");

endmodule

`default_nettype wire

FILE: sim/first_seen_key_filter_unit_tb.sv
`default_nettype none

module first_seen_key_filter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fkf_pkg::*;

    localparam int TABLE_SLOTS = 4096;

    // Command code with no meaning to the block; it must behave as a no-op.
    localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;

    // One result beat as the block should return it.
    typedef struct {
        status_t           status;
        logic [POS_W-1:0]  position;
        logic [KEY_W-1:0]  hashed_key;
    } verdict_t;

    // A detection record kept around so that it can be sent again as a duplicate.
    typedef struct {
        logic [MAC_W-1:0]  mac;
        logic [TYPE_W-1:0] dtype;
    } sighting_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    // Mirror of the key set, the occupancy and the detection position.
    bit                    seen_valid [TABLE_SLOTS];
    logic [KEY_W-1:0]      seen_key [TABLE_SLOTS];
    int unsigned           seen_count = 0;
    logic [POS_W-1:0]      detect_pos = '0;

    verdict_t              sighting_verdicts [$];
    int                    mismatch_count = 0;
    int                    src_idle_pct = 0;
    int                    sink_stall_pct = 0;

    first_seen_key_filter_unit #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // 32-bit FNV-1a over the six MAC bytes, first byte first, then the type byte.
    function automatic logic [KEY_W-1:0] fnv1a_sighting(logic [MAC_W-1:0] mac,
                                                        logic [TYPE_W-1:0] dtype);
        logic [KEY_W-1:0] h;
        h = 32'd2166136261;
        for (int b = 5; b >= 0; b--) begin
            h = (h ^ {24'd0, mac[8*b +: 8]}) * 32'd16777619;
        end
        h = (h ^ {24'd0, dtype}) * 32'd16777619;
        return (h == '0) ? 32'd1 : h;
    endfunction

    // Linear-probing insert into the mirror set, refusing once half the slots are used.
    function automatic status_t insert_key(logic [KEY_W-1:0] k);
        int unsigned idx;
        if ((seen_count + 1) * 2 > TABLE_SLOTS) begin
            return ST_FULL;
        end
        idx = k % 32'(TABLE_SLOTS);
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if (!seen_valid[idx]) begin
                seen_valid[idx] = 1'b1;
                seen_key[idx]   = k;
                seen_count++;
                return ST_NEW;
            end
            if (seen_key[idx] == k) begin
                return ST_DUP;
            end
            idx = (idx + 1) % TABLE_SLOTS;
        end
        return ST_FULL;
    endfunction

    // Works out the result of one accepted beat and updates the mirror state.
    function automatic verdict_t judge_beat(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] ring_key,
                                            logic [MAC_W-1:0] mac, logic [TYPE_W-1:0] dtype);
        verdict_t v;
        v.status     = ST_NEW;
        v.position   = '0;
        v.hashed_key = '0;
        case (cmd)
            CMD_CLEAR:
            begin
                foreach (seen_valid[i]) seen_valid[i] = 1'b0;
                seen_count = 0;
                detect_pos = '0;
            end
            CMD_SEED:
            begin
                v.hashed_key = ring_key;
                v.status     = insert_key(ring_key);
            end
            CMD_DETECT:
            begin
                v.hashed_key = fnv1a_sighting(mac, dtype);
                v.status     = insert_key(v.hashed_key);
                if (v.status == ST_NEW) begin
                    v.position = detect_pos;
                end
                if (v.status != ST_FULL) begin
                    detect_pos = detect_pos + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return v;
    endfunction

    // Finds a record whose raw hash is zero. The state after the sixth MAC byte must
    // equal the type byte, so the last MAC byte is solved through the inverse prime.
    function automatic void find_zero_hash_sighting(output logic [MAC_W-1:0] mac,
                                                    output logic [TYPE_W-1:0] dtype);
        logic [KEY_W-1:0] p_inv, s2, s3, s4, s5, v;
        int               y_of [logic [23:0]];
        int               y;
        p_inv = 32'd16777619;
        repeat (5) p_inv = p_inv * (32'd2 - 32'd16777619 * p_inv);
        for (int i = 0; i < 256; i++) begin
            v = 32'(i) * p_inv;
            y_of[v[31:8]] = i;
        end
        s2 = ((32'd2166136261 * 32'd16777619)) * 32'd16777619;
        mac   = '0;
        dtype = '0;
        for (int b2 = 0; b2 < 256; b2++) begin
            s3 = (s2 ^ 32'(b2)) * 32'd16777619;
            for (int b3 = 0; b3 < 256; b3++) begin
                s4 = (s3 ^ 32'(b3)) * 32'd16777619;
                for (int b4 = 0; b4 < 256; b4++) begin
                    s5 = (s4 ^ 32'(b4)) * 32'd16777619;
                    if (y_of.exists(s5[31:8])) begin
                        y     = y_of[s5[31:8]];
                        v     = 32'(y) * p_inv;
                        mac   = {16'd0, 8'(b2), 8'(b3), 8'(b4), s5[7:0] ^ v[7:0]};
                        dtype = 8'(y);
                        return;
                    end
                end
            end
        end
    endfunction

    // Sends one beat after a random idle gap and records its expected result.
    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] ring_key,
                             logic [MAC_W-1:0] mac, logic [TYPE_W-1:0] dtype);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dtype, mac, ring_key};
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (!s_axis_tready);
        sighting_verdicts.push_back(judge_beat(cmd, ring_key, mac, dtype));
    endtask

    // Holds the input off until every outstanding result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sighting_verdicts.size() != 0) @(posedge clk);
    endtask

    task automatic set_idling(int src_pct, int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    task automatic compare_field(string name, logic [KEY_W-1:0] expected, logic [KEY_W-1:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expected, actual);
            mismatch_count++;
        end
    endtask

    // Checks each output beat against the oldest expectation and drives the sink stall.
    always @(posedge clk) begin
        verdict_t v;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (sighting_verdicts.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got status %0d key %0h",
                             $time, m_axis_tuser, m_axis_tdata[47:16]);
                    mismatch_count++;
                end
                else begin
                    v = sighting_verdicts.pop_front();
                    compare_field("status", 32'(v.status), 32'(m_axis_tuser));
                    compare_field("position", 32'(v.position), 32'(m_axis_tdata[15:0]));
                    compare_field("hashed_key", v.hashed_key, m_axis_tdata[47:16]);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Extremes of the fields, probing across the wrap, zero keys and the no-op command.
    task automatic test_directed_cases();
        logic [MAC_W-1:0]  zmac;
        logic [TYPE_W-1:0] ztype;
        find_zero_hash_sighting(zmac, ztype);
        send_beat(CMD_DETECT, 32'hFFFF_FFFF, '0, '0);
        send_beat(CMD_DETECT, '0, '1, '1);
        send_beat(CMD_DETECT, 32'h1234_5678, '0, '0);
        send_beat(CMD_SEED, 32'd4095, '1, '1);
        send_beat(CMD_SEED, 32'd8191, '0, '0);
        send_beat(CMD_SEED, 32'd0, '1, '0);
        send_beat(CMD_SEED, 32'd0, '0, '1);
        send_beat(CMD_SEED, 32'hFFFF_FFFF, '0, '0);
        send_beat(CMD_SEED, 32'd4096, '0, '0);
        send_beat(CMD_UNDEFINED, 32'hFFFF_FFFF, '1, '1);
        send_beat(CMD_DETECT, '0, zmac, ztype);
        send_beat(CMD_SEED, 32'd1, '0, '0);
        send_beat(CMD_DETECT, '1, zmac, ztype);
        send_beat(CMD_SEED, fnv1a_sighting('1, '1), '0, '0);
        send_beat(CMD_CLEAR, '1, '1, '1);
        send_beat(CMD_DETECT, '0, '0, '0);
        send_beat(CMD_SEED, 32'd0, '0, '0);
        send_beat(CMD_DETECT, '0, 48'h8000_0000_0001, 8'h80);
        wait_for_results();
    endtask

    // Builds a run of occupied slots across the end of the table, then sends keys that
    // probe all the way through it, a duplicate inside it, and a clear that empties it.
    task automatic test_probe_cluster();
        send_beat(CMD_CLEAR, '0, '0, '0);
        for (int k = 0; k < 16; k++) begin
            send_beat(CMD_SEED, 32'(TABLE_SLOTS - 8 + k), '0, '0);
        end
        send_beat(CMD_SEED, 32'(2 * TABLE_SLOTS - 8), '0, '0);
        send_beat(CMD_SEED, 32'(TABLE_SLOTS + 4), '0, '0);
        send_beat(CMD_SEED, 32'(2 * TABLE_SLOTS - 8), '0, '0);
        send_beat(CMD_DETECT, '0, 48'h0011_2233_4455, 8'h66);
        send_beat(CMD_DETECT, '0, 48'h0011_2233_4455, 8'h66);
        send_beat(CMD_CLEAR, '0, '0, '0);
        send_beat(CMD_DETECT, '0, 48'h0011_2233_4455, 8'h66);
        wait_for_results();
    endtask

    // Mostly detection records, with repeats, seeds in clusters, clears and no-ops.
    task automatic test_random_traffic(int count);
        int               pick;
        logic [KEY_W-1:0] k;
        logic [MAC_W-1:0] m;
        logic [TYPE_W-1:0] t;
        sighting_t        s;
        sighting_t        recent [$];
        logic [KEY_W-1:0] recent_keys [$];
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            k = $urandom;
            m = 48'({$urandom, $urandom});
            t = 8'($urandom);
            if (pick < 3) begin
                wait_for_results();
            end
            else if (pick < 6) begin
                send_beat(CMD_CLEAR, k, m, t);
            end
            else if (pick < 8) begin
                send_beat(CMD_UNDEFINED, k, m, t);
            end
            else if (pick < 30) begin
                case ($urandom_range(3))
                    0: k = $urandom;
                    1: if (recent_keys.size() != 0)
                        k = recent_keys[$urandom_range(recent_keys.size() - 1)];
                    2: k = $urandom_range(15);
                    default: k = 32'(TABLE_SLOTS) * $urandom_range(7) + $urandom_range(3);
                endcase
                send_beat(CMD_SEED, k, m, t);
                recent_keys.push_back(k);
            end
            else begin
                if (recent.size() != 0 && $urandom_range(99) < 40) begin
                    s = recent[$urandom_range(recent.size() - 1)];
                    m = s.mac;
                    if ($urandom_range(3) != 0) t = s.dtype;
                end
                send_beat(CMD_DETECT, k, m, t);
                s.mac   = m;
                s.dtype = t;
                recent.push_back(s);
                recent_keys.push_back(fnv1a_sighting(m, t));
            end
            if (recent.size() > 24) void'(recent.pop_front());
            if (recent_keys.size() > 24) void'(recent_keys.pop_front());
        end
        wait_for_results();
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(0, 0);
        test_directed_cases();
        test_probe_cluster();
        test_random_traffic(150);
        set_idling(60, 0);
        test_random_traffic(150);
        set_idling(0, 60);
        test_random_traffic(150);
        set_idling(8, 8);
        test_random_traffic(150);
        repeat (64) @(posedge clk);
        if (mismatch_count == 0 && sighting_verdicts.size() == 0) begin
            $display("status: pass");
        end
        else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
